// ===== rtl/cfts_pkg.sv =====
// Shared types, constants and helpers of the cube-face tile center block.
package cfts_pkg;

  localparam int unsigned MaxLevel  = 16;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;
  // Front stages, square root, divider setup, divider, two scale stages and the output register.
  localparam int unsigned Latency   = 10 + SqrtSteps + 1 + DivSteps + 3;

  localparam logic signed [31:0] OneQ30   = 32'sh4000_0000;
  localparam logic signed [36:0] OneQ30W  = 37'sd1073741824;
  localparam logic [36:0]        PLimit   = 37'd268435456;
  localparam logic [37:0]        RLimit   = 38'd2147483648;

  typedef enum logic [2:0] {
    REG_ROT_W    = 3'd0,
    REG_ROT_X    = 3'd1,
    REG_ROT_Y    = 3'd2,
    REG_ROT_Z    = 3'd3,
    REG_RADIUS   = 3'd4,
    REG_CENTRE_X = 3'd5,
    REG_CENTRE_Y = 3'd6,
    REG_CENTRE_Z = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic [4:0]         tile_level;
    logic [15:0]        tile_col;
    logic [15:0]        tile_row;
  } tile_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic               range_flag;
  } tile_out_t;

  // Rotated vector as sign and magnitude, carried through the square root.
  typedef struct packed {
    logic             bad;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } vec_cargo_t;

  // One step of the restoring divider, all three components side by side.
  typedef struct packed {
    logic             bad;
    logic [2:0]       neg;
    logic [31:0]      len;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] lo;
    logic [2:0][30:0] quo;
  } div_t;

  // Arithmetic right shift by k that rounds half up.
  function automatic logic signed [65:0] rsh66(input logic signed [65:0] v,
                                                input int unsigned k);
    logic signed [65:0] sh;
    sh = v >>> k;
    return sh + {65'b0, v[k-1]};
  endfunction

endpackage

// ===== rtl/cube_face_tile_center_on_sphere_core.sv =====
// Top level: tile center on a rotated, scaled and placed cube-sphere, fully pipelined.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid_i, in_ready_o, in_data_i        | input
//   out      | out_valid_o, out_ready_i, out_data_o     | output
//   cfg      | cfg_we_i, cfg_idx_i, cfg_data_i          | input
//
// One transfer is taken per cycle while the output is not held; each passes through
// the 32-step square root and the 31-step divider, one step per stage.
// Reset restores the quaternion to identity, the radius to 1.0 and the center to zero.
// When the output is held, the whole pipeline holds and in_ready_o drops.
module cube_face_tile_center_on_sphere_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cfts_pkg::tile_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfts_pkg::tile_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [47:0]          cfg_data_i
);
  import cfts_pkg::*;

  logic signed [31:0] rot_q [4];
  logic [39:0]        radius_q;
  logic signed [47:0] centre_q [3];

  logic               adv;
  logic               vld_q [Latency];

  // Front stages.
  logic               s1_bad_d, s1_bad_q;
  logic signed [31:0] s1_scol_d, s1_scol_q, s1_srow_d, s1_srow_q;
  logic signed [31:0] u_in [3];
  logic signed [31:0] s1_u_q [3];
  logic signed [63:0] s1_pr_d [6];
  logic signed [63:0] s1_pr_q [6];
  logic [4:0]         lvl;
  logic [5:0]         sh_amt;
  logic [47:0]        ext_c, ext_r;

  logic               s2_bad_q;
  logic signed [31:0] s2_u_q [3];
  logic signed [31:0] s2_srow_q;
  logic signed [33:0] s2_b_d [3];
  logic signed [33:0] s2_b_q [3];
  logic signed [63:0] s2_t1_d [3];
  logic signed [63:0] s2_t1_q [3];
  logic signed [64:0] diff [3];
  logic signed [65:0] rtmp2 [3];

  logic               s3_bad_q;
  logic signed [31:0] s3_u_q [3];
  logic signed [33:0] s3_t1r_d [3];
  logic signed [33:0] s3_t1r_q [3];
  logic signed [65:0] s3_t2_d [3];
  logic signed [65:0] s3_t2_q [3];
  logic signed [65:0] rtmp3 [3];

  logic               s4_bad_q;
  logic signed [36:0] s4_p_d [3];
  logic signed [36:0] s4_p_q [3];
  logic signed [65:0] rtmp4 [3];

  logic               s5_bad_q;
  logic signed [28:0] s5_p_d [3];
  logic signed [28:0] s5_p_q [3];
  logic [36:0]        pmag [3];
  logic [36:0]        por;
  logic [3:0]         pk;
  logic signed [36:0] psh [3];

  logic signed [63:0] qp_d [9];
  logic signed [63:0] qp_q [9];
  logic signed [36:0] qt [9];
  logic signed [36:0] m_d [3][3];
  logic signed [36:0] m_q [3][3];

  logic               s6_bad_q;
  logic signed [65:0] s6_mp_d [3][3];
  logic signed [65:0] s6_mp_q [3][3];

  logic               s7_bad_q;
  logic signed [37:0] s7_r_d [3];
  logic signed [37:0] s7_r_q [3];
  logic signed [65:0] rtmp7 [3][3];

  vec_cargo_t         s8_c_d, s8_c_q;
  logic [37:0]        rmag [3];
  logic [37:0]        ror;
  logic [3:0]         rk;
  logic signed [37:0] rsh_v [3];
  logic signed [31:0] rs [3];

  vec_cargo_t         s9_c_q;
  logic [63:0]        s9_sq_d [3];
  logic [63:0]        s9_sq_q [3];

  vec_cargo_t         s10_c_q;
  logic [63:0]        s10_sum_d, s10_sum_q;

  // Square root.
  logic [63:0]        sq_x_in [SqrtSteps];
  logic [63:0]        sq_r_in [SqrtSteps];
  vec_cargo_t         sq_c_in [SqrtSteps];
  logic [63:0]        sq_x_d [SqrtSteps];
  logic [63:0]        sq_r_d [SqrtSteps];
  logic [63:0]        sq_x_q [SqrtSteps];
  logic [63:0]        sq_r_q [SqrtSteps];
  vec_cargo_t         sq_c_q [SqrtSteps];
  logic [63:0]        sq_bit;
  logic [64:0]        sq_trial;

  // Divider.
  div_t               dp_d, dp_q;
  logic [31:0]        dlen;
  logic [62:0]        num;
  div_t               dv_in [DivSteps];
  div_t               dv_d [DivSteps];
  div_t               dv_q [DivSteps];
  logic [32:0]        dcur;
  logic               dge;

  // Scale and place.
  logic               c1_bad_q, c2_bad_q;
  logic [2:0]         c1_neg_q, c2_neg_q;
  logic [50:0]        c1_hi_d [3];
  logic [50:0]        c1_lo_d [3];
  logic [50:0]        c1_hi_q [3];
  logic [50:0]        c1_lo_q [3];
  logic [40:0]        c2_q_d [3];
  logic [40:0]        c2_q_q [3];
  logic [71:0]        c2_sum [3];
  tile_out_t          out_d, out_q;
  logic signed [49:0] sv [3];
  logic signed [49:0] cen [3];
  logic signed [49:0] tot [3];
  logic signed [47:0] pos [3];
  logic               sat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]    <= OneQ30;
      rot_q[1]    <= '0;
      rot_q[2]    <= '0;
      rot_q[3]    <= '0;
      radius_q    <= 40'd65536;
      centre_q[0] <= '0;
      centre_q[1] <= '0;
      centre_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_ROT_W:    rot_q[0]    <= cfg_data_i[31:0];
        REG_ROT_X:    rot_q[1]    <= cfg_data_i[31:0];
        REG_ROT_Y:    rot_q[2]    <= cfg_data_i[31:0];
        REG_ROT_Z:    rot_q[3]    <= cfg_data_i[31:0];
        REG_RADIUS:   radius_q    <= cfg_data_i[39:0];
        REG_CENTRE_X: centre_q[0] <= cfg_data_i;
        REG_CENTRE_Y: centre_q[1] <= cfg_data_i;
        REG_CENTRE_Z: centre_q[2] <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // The whole pipeline moves together unless a finished result is waiting.
  assign adv         = !vld_q[Latency-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Latency-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Latency; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < Latency; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Quaternion rotation matrix; the user must keep registers static while items are in flight.
  always_comb begin
    qp_d[0] = 64'(rot_q[1]) * 64'(rot_q[1]);
    qp_d[1] = 64'(rot_q[2]) * 64'(rot_q[2]);
    qp_d[2] = 64'(rot_q[3]) * 64'(rot_q[3]);
    qp_d[3] = 64'(rot_q[1]) * 64'(rot_q[2]);
    qp_d[4] = 64'(rot_q[1]) * 64'(rot_q[3]);
    qp_d[5] = 64'(rot_q[2]) * 64'(rot_q[3]);
    qp_d[6] = 64'(rot_q[0]) * 64'(rot_q[1]);
    qp_d[7] = 64'(rot_q[0]) * 64'(rot_q[2]);
    qp_d[8] = 64'(rot_q[0]) * 64'(rot_q[3]);
    for (int i = 0; i < 9; i++) qt[i] = 37'(rsh66(66'(qp_q[i]), 29));
    m_d[0][0] = OneQ30W - (qt[1] + qt[2]);
    m_d[0][1] = qt[3] - qt[8];
    m_d[0][2] = qt[4] + qt[7];
    m_d[1][0] = qt[3] + qt[8];
    m_d[1][1] = OneQ30W - (qt[0] + qt[2]);
    m_d[1][2] = qt[5] - qt[6];
    m_d[2][0] = qt[4] - qt[7];
    m_d[2][1] = qt[5] + qt[6];
    m_d[2][2] = OneQ30W - (qt[0] + qt[1]);
  end

  always_ff @(posedge clk_i) begin
    qp_q <= qp_d;
    m_q  <= m_d;
  end

  // Stage 1: range check, tile offsets, products for the second face axis.
  always_comb begin
    lvl      = in_data_i.tile_level;
    u_in[0]  = in_data_i.up_x;
    u_in[1]  = in_data_i.up_y;
    u_in[2]  = in_data_i.up_z;
    s1_bad_d = (lvl > 5'(MaxLevel)) || ((in_data_i.tile_col >> lvl) != '0) ||
               ((in_data_i.tile_row >> lvl) != '0);
    sh_amt    = 6'd30 - {1'b0, lvl};
    ext_c     = {31'b0, in_data_i.tile_col, 1'b1} << sh_amt;
    ext_r     = {31'b0, in_data_i.tile_row, 1'b1} << sh_amt;
    s1_scol_d = $signed(ext_c[31:0]) - OneQ30;
    s1_srow_d = $signed(ext_r[31:0]) - OneQ30;
    s1_pr_d[0] = 64'(u_in[1]) * 64'(u_in[0]);
    s1_pr_d[1] = 64'(u_in[2]) * 64'(u_in[2]);
    s1_pr_d[2] = 64'(u_in[2]) * 64'(u_in[1]);
    s1_pr_d[3] = 64'(u_in[0]) * 64'(u_in[0]);
    s1_pr_d[4] = 64'(u_in[0]) * 64'(u_in[2]);
    s1_pr_d[5] = 64'(u_in[1]) * 64'(u_in[1]);
  end

  // Stage 2: second face axis, first offset products (axis a is up with rotated components).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = 65'(s1_pr_q[2*i]) - 65'(s1_pr_q[2*i+1]);
      rtmp2[i]   = rsh66(66'(diff[i]), 30);
      s2_b_d[i]  = 34'(rtmp2[i]);
      s2_t1_d[i] = 64'(s1_scol_q) * 64'(s1_u_q[(i+1)%3]);
    end
  end

  // Stage 3: second offset products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rtmp3[i]    = rsh66(66'(s2_t1_q[i]), 30);
      s3_t1r_d[i] = 34'(rtmp3[i]);
      s3_t2_d[i]  = 66'(s2_srow_q) * 66'(s2_b_q[i]);
    end
  end

  // Stage 4: point on the cube face.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rtmp4[i]  = rsh66(s3_t2_q[i], 30);
      s4_p_d[i] = 37'(s3_u_q[i]) + 37'(s3_t1r_q[i]) + 37'(rtmp4[i]);
    end
  end

  // Stage 5: common floor shift so every component stays below 2^28 in magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) pmag[i] = s4_p_q[i][36] ? 37'(-s4_p_q[i]) : 37'(s4_p_q[i]);
    por = pmag[0] | pmag[1] | pmag[2];
    pk  = '0;
    for (int j = 0; j < 9; j++) if ((por >> j) >= PLimit) pk = 4'(j + 1);
    for (int i = 0; i < 3; i++) begin
      psh[i]    = s4_p_q[i] >>> pk;
      s5_p_d[i] = psh[i][28:0];
    end
  end

  // Stage 6: matrix times vector products.
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        s6_mp_d[i][j] = 66'(m_q[i][j]) * 66'(s5_p_q[j]);
  end

  // Stage 7: rotated vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) rtmp7[i][j] = rsh66(s6_mp_q[i][j], 30);
      s7_r_d[i] = 38'(rtmp7[i][0]) + 38'(rtmp7[i][1]) + 38'(rtmp7[i][2]);
    end
  end

  // Stage 8: common floor shift below 2^31, zero check, sign and magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) rmag[i] = s7_r_q[i][37] ? 38'(-s7_r_q[i]) : 38'(s7_r_q[i]);
    ror = rmag[0] | rmag[1] | rmag[2];
    rk  = '0;
    for (int j = 0; j < 9; j++) if ((ror >> j) >= RLimit) rk = 4'(j + 1);
    for (int i = 0; i < 3; i++) begin
      rsh_v[i]         = s7_r_q[i] >>> rk;
      rs[i]            = rsh_v[i][31:0];
      s8_c_d.neg[i]    = rs[i][31];
      s8_c_d.mag[i]    = rs[i][31] ? 32'(-rs[i]) : 32'(rs[i]);
    end
    s8_c_d.bad = s7_bad_q || ((rs[0] == '0) && (rs[1] == '0) && (rs[2] == '0));
  end

  // Stages 9 and 10: squared length.
  always_comb begin
    for (int i = 0; i < 3; i++) s9_sq_d[i] = 64'(s8_c_q.mag[i]) * 64'(s8_c_q.mag[i]);
    s10_sum_d = s9_sq_q[0] + s9_sq_q[1] + s9_sq_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_bad_q  <= s1_bad_d;
      s1_scol_q <= s1_scol_d;
      s1_srow_q <= s1_srow_d;
      s1_u_q    <= u_in;
      s1_pr_q   <= s1_pr_d;
      s2_bad_q  <= s1_bad_q;
      s2_u_q    <= s1_u_q;
      s2_srow_q <= s1_srow_q;
      s2_b_q    <= s2_b_d;
      s2_t1_q   <= s2_t1_d;
      s3_bad_q  <= s2_bad_q;
      s3_u_q    <= s2_u_q;
      s3_t1r_q  <= s3_t1r_d;
      s3_t2_q   <= s3_t2_d;
      s4_bad_q  <= s3_bad_q;
      s4_p_q    <= s4_p_d;
      s5_bad_q  <= s4_bad_q;
      s5_p_q    <= s5_p_d;
      s6_bad_q  <= s5_bad_q;
      s6_mp_q   <= s6_mp_d;
      s7_bad_q  <= s6_bad_q;
      s7_r_q    <= s7_r_d;
      s8_c_q    <= s8_c_d;
      s9_c_q    <= s8_c_q;
      s9_sq_q   <= s9_sq_d;
      s10_c_q   <= s9_c_q;
      s10_sum_q <= s10_sum_d;
    end
  end

  // Integer square root, one result bit per stage.
  always_comb begin
    sq_x_in[0] = s10_sum_q;
    sq_r_in[0] = '0;
    sq_c_in[0] = s10_c_q;
    for (int i = 1; i < SqrtSteps; i++) begin
      sq_x_in[i] = sq_x_q[i-1];
      sq_r_in[i] = sq_r_q[i-1];
      sq_c_in[i] = sq_c_q[i-1];
    end
    for (int i = 0; i < SqrtSteps; i++) begin
      sq_bit   = 64'd1 << (62 - 2 * i);
      sq_trial = 65'(sq_r_in[i]) + 65'(sq_bit);
      if (65'(sq_x_in[i]) >= sq_trial) begin
        sq_x_d[i] = sq_x_in[i] - sq_trial[63:0];
        sq_r_d[i] = (sq_r_in[i] >> 1) + sq_bit;
      end else begin
        sq_x_d[i] = sq_x_in[i];
        sq_r_d[i] = sq_r_in[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_x_q <= sq_x_d;
      sq_r_q <= sq_r_d;
      sq_c_q <= sq_c_in;
    end
  end

  // Divider setup: rounded numerator for each component over the length.
  always_comb begin
    dlen       = sq_r_q[SqrtSteps-1][31:0];
    dp_d       = '0;
    dp_d.bad   = sq_c_q[SqrtSteps-1].bad;
    dp_d.neg   = sq_c_q[SqrtSteps-1].neg;
    dp_d.len   = dlen;
    for (int k = 0; k < 3; k++) begin
      num          = {1'b0, sq_c_q[SqrtSteps-1].mag[k], 30'b0} + {32'b0, dlen[31:1]};
      dp_d.rem[k]  = num[62:31];
      dp_d.lo[k]   = num[30:0];
    end
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    dv_in[0] = dp_q;
    for (int j = 1; j < DivSteps; j++) dv_in[j] = dv_q[j-1];
    for (int j = 0; j < DivSteps; j++) begin
      dv_d[j] = dv_in[j];
      for (int k = 0; k < 3; k++) begin
        dcur = {dv_in[j].rem[k], dv_in[j].lo[k][30]};
        dge  = dcur >= {1'b0, dv_in[j].len};
        dv_d[j].rem[k] = dge ? 32'(dcur - {1'b0, dv_in[j].len}) : dcur[31:0];
        dv_d[j].lo[k]  = {dv_in[j].lo[k][29:0], 1'b0};
        dv_d[j].quo[k] = {dv_in[j].quo[k][29:0], dge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_q <= dp_d;
      dv_q <= dv_d;
    end
  end

  // Scale by the radius in two partial products, then round.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c1_hi_d[k] = 51'(dv_q[DivSteps-1].quo[k]) * 51'(radius_q[39:20]);
      c1_lo_d[k] = 51'(dv_q[DivSteps-1].quo[k]) * 51'(radius_q[19:0]);
      c2_sum[k]  = 72'({c1_hi_q[k], 20'b0}) + 72'(c1_lo_q[k]) + 72'(1) * 72'(1 << 29);
      c2_q_d[k]  = c2_sum[k][70:30];
    end
  end

  // Sign, center offset and saturation to 48 bits; a bad item gives the center and range_flag.
  always_comb begin
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sv[k]  = c2_neg_q[k] ? -$signed({9'b0, c2_q_q[k]}) : $signed({9'b0, c2_q_q[k]});
      cen[k] = 50'(centre_q[k]);
      tot[k] = sv[k] + cen[k];
      if (!tot[k][49] && (tot[k][48:47] != 2'b00)) begin
        pos[k] = {1'b0, {47{1'b1}}};
        sat    = 1'b1;
      end else if (tot[k][49] && (tot[k][48:47] != 2'b11)) begin
        pos[k] = {1'b1, {47{1'b0}}};
        sat    = 1'b1;
      end else begin
        pos[k] = tot[k][47:0];
      end
    end
    if (c2_bad_q) begin
      out_d.pos_x      = centre_q[0];
      out_d.pos_y      = centre_q[1];
      out_d.pos_z      = centre_q[2];
      out_d.range_flag = 1'b1;
    end else begin
      out_d.pos_x      = pos[0];
      out_d.pos_y      = pos[1];
      out_d.pos_z      = pos[2];
      out_d.range_flag = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_bad_q <= dv_q[DivSteps-1].bad;
      c1_neg_q <= dv_q[DivSteps-1].neg;
      c1_hi_q  <= c1_hi_d;
      c1_lo_q  <= c1_lo_d;
      c2_bad_q <= c1_bad_q;
      c2_neg_q <= c1_neg_q;
      c2_q_q   <= c2_q_d;
      out_q    <= out_d;
    end
  end

endmodule
